>>> rtl/mtae_pkg.sv
package mtae_pkg;

    localparam int LEVEL_W = 7;
    localparam int TIME_W  = 32;
    localparam int SPAN_W  = 16;
    localparam int QBITS   = 7;
    localparam int STAGE_W = 3;
    localparam int CMD_W   = 2;
    localparam int TRK_W   = 3;
    localparam int REG_W   = 3;
    localparam int MASK_W  = 8;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRIGGER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET   = 2'd3;

    localparam logic [STAGE_W-1:0] STG_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] STG_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] STG_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] STG_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] STG_RELEASE = 3'd4;

    localparam logic [REG_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [REG_W-1:0] REG_ATTACK  = 3'd1;
    localparam logic [REG_W-1:0] REG_DECAY   = 3'd2;
    localparam logic [REG_W-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [REG_W-1:0] REG_RELEASE = 3'd4;
    localparam logic [REG_W-1:0] REG_FLOOR   = 3'd5;
    localparam logic [REG_W-1:0] REG_CEILING = 3'd6;

    localparam logic [MASK_W-1:0]  ENABLE_RST  = 8'd0;
    localparam logic [SPAN_W-1:0]  ATTACK_RST  = 16'd100;
    localparam logic [SPAN_W-1:0]  DECAY_RST   = 16'd200;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 7'd100;
    localparam logic [SPAN_W-1:0]  RELEASE_RST = 16'd300;
    localparam logic [LEVEL_W-1:0] FLOOR_RST   = 7'd0;
    localparam logic [LEVEL_W-1:0] CEILING_RST = 7'd127;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_CALC,
        FSM_DIV,
        FSM_EMIT,
        FSM_FLUSH
    } fsm_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] diff;
        logic [SPAN_W-1:0]  elapsed;
        logic [SPAN_W-1:0]  span;
    } ramp_req_t;

endpackage

>>> rtl/mtae_ramp.sv
module mtae_ramp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  mtae_pkg::ramp_req_t              req,
    output logic                             busy,
    output logic [mtae_pkg::QBITS-1:0]       quot
);

    localparam int PROD_W = mtae_pkg::LEVEL_W + mtae_pkg::SPAN_W;
    localparam int DVS_W  = mtae_pkg::SPAN_W + mtae_pkg::QBITS - 1;
    localparam int CNT_W  = $clog2(mtae_pkg::QBITS + 1);

    logic [PROD_W-1:0]          rem_reg, rem_next;
    logic [DVS_W-1:0]           dvs_reg, dvs_next;
    logic [mtae_pkg::QBITS-1:0] q_reg, q_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       fits;

    // Restoring division, one quotient bit per cycle, most significant first.
    assign fits = rem_reg >= PROD_W'(dvs_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = PROD_W'(req.diff) * PROD_W'(req.elapsed);
            dvs_next  = {req.span, {(mtae_pkg::QBITS-1){1'b0}}};
            q_next    = '0;
            cnt_next  = CNT_W'(mtae_pkg::QBITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - PROD_W'(dvs_reg);
            end
            q_next   = {q_reg[mtae_pkg::QBITS-2:0], fits};
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

>>> rtl/multi_track_adsr_envelope.sv
// Linear ADSR envelope for up to eight tracks with shared timing and level settings.
// Commands arrive on the slave stream: a tick walks the tracks in ascending order and
// sends one transfer for every enabled, active track whose level changed, the last one
// flagged by tlast; trigger and release send nothing; a track reset sends exactly one
// transfer. A tick visits every track; a track at a fixed level also passes the calc
// and emit states, and a track on a ramp also waits in the division state for the
// serial divider, which forms one quotient bit per cycle. Output back-pressure can
// hold the walk in the emit and flush states.
// Configuration writes are taken at any time but belong between commands.
module multi_track_adsr_envelope #(
    parameter int TRACKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // track [2:0], time_ms [34:3], zero [39:35]
    input  logic [1:0]  s_tuser,    // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // track_out [2:0], level [9:3], stage_out [12:10], zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NT = (TRACKS < 8) ? TRACKS : 8;
    localparam int IW = (NT > 1) ? $clog2(NT) : 1;
    localparam int LW = mtae_pkg::LEVEL_W;
    localparam int TW = mtae_pkg::TIME_W;
    localparam int SW = mtae_pkg::SPAN_W;
    localparam int GW = mtae_pkg::STAGE_W;
    localparam int KW = mtae_pkg::TRK_W;

    mtae_pkg::fsm_t state_reg, state_next;

    logic [mtae_pkg::MASK_W-1:0] enable_reg, enable_next;
    logic [SW-1:0] attack_reg, attack_next;
    logic [SW-1:0] decay_reg, decay_next;
    logic [LW-1:0] sustain_reg, sustain_next;
    logic [SW-1:0] release_reg, release_next;
    logic [LW-1:0] floor_reg, floor_next;
    logic [LW-1:0] ceiling_reg, ceiling_next;

    logic [GW-1:0] stage_reg [NT];
    logic [GW-1:0] stage_next [NT];
    logic [TW-1:0] start_reg [NT];
    logic [TW-1:0] start_next [NT];
    logic [LW-1:0] sent_reg [NT];
    logic [LW-1:0] sent_next [NT];

    logic [IW-1:0] t_reg, t_next;
    logic [TW-1:0] now_reg, now_next;
    logic [TW-1:0] elapsed_reg, elapsed_next;
    logic          early_reg, early_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [LW-1:0] base_reg, base_next;
    logic          up_reg, up_next;

    logic          pend_valid_reg, pend_valid_next;
    logic [KW-1:0] pend_track_reg, pend_track_next;
    logic [LW-1:0] pend_level_reg, pend_level_next;
    logic [GW-1:0] pend_stage_reg, pend_stage_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic          m_tlast_reg, m_tlast_next;
    logic [KW-1:0] out_track_reg, out_track_next;
    logic [LW-1:0] out_level_reg, out_level_next;
    logic [GW-1:0] out_stage_reg, out_stage_next;

    logic [KW-1:0] in_track;
    logic [TW-1:0] in_time;
    logic [IW-1:0] idx;
    logic [NT-1:0] en_vec;
    logic [GW-1:0] cur_stage;
    logic [TW-1:0] cur_start;
    logic [TW-1:0] start_eff;
    logic          trk_ok;
    logic          trk_active;
    logic          walk_last;
    logic          out_free;
    logic          emit_change;
    logic          emit_wait;

    logic          calc_ramp;
    logic          calc_move;
    logic [GW-1:0] calc_stage;
    logic [LW-1:0] calc_lvl;
    logic [LW-1:0] calc_base;
    logic          calc_up;
    mtae_pkg::ramp_req_t calc_req;

    logic          ramp_start;
    logic          ramp_busy;
    logic [mtae_pkg::QBITS-1:0] ramp_quot;

    mtae_ramp u_ramp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ramp_start),
        .req   (calc_req),
        .busy  (ramp_busy),
        .quot  (ramp_quot)
    );

    assign in_track   = s_tdata[KW-1:0];
    assign in_time    = s_tdata[KW+TW-1:KW];
    assign idx        = (state_reg == mtae_pkg::FSM_IDLE) ? IW'(in_track) : t_reg;
    assign en_vec     = enable_reg[NT-1:0];
    assign cur_stage  = stage_reg[idx];
    assign cur_start  = start_reg[idx];
    assign start_eff  = (cur_start == '0) ? now_reg : cur_start;
    assign trk_ok     = {1'b0, in_track} < (KW+1)'(NT);
    assign trk_active = en_vec[idx] && (cur_stage != mtae_pkg::STG_IDLE);
    assign walk_last  = t_reg == IW'(NT - 1);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign emit_change = lvl_reg != sent_reg[idx];
    assign emit_wait  = emit_change && pend_valid_reg && !out_free;

    // Level decision for the stage, made once the elapsed time is registered.
    always_comb
    begin
        calc_ramp  = 1'b0;
        calc_move  = 1'b0;
        calc_stage = cur_stage;
        calc_lvl   = floor_reg;
        calc_base  = floor_reg;
        calc_up    = 1'b1;
        calc_req   = '{diff: '0, elapsed: elapsed_reg[SW-1:0], span: attack_reg};
        if (!early_reg)
        begin
            case (cur_stage)
                mtae_pkg::STG_ATTACK:
                begin
                    if (elapsed_reg >= TW'(attack_reg))
                    begin
                        calc_lvl   = ceiling_reg;
                        calc_move  = 1'b1;
                        calc_stage = mtae_pkg::STG_DECAY;
                    end
                    else if (floor_reg <= ceiling_reg)
                    begin
                        calc_ramp     = 1'b1;
                        calc_req.diff = ceiling_reg - floor_reg;
                    end
                end
                mtae_pkg::STG_DECAY:
                begin
                    if (elapsed_reg >= TW'(decay_reg))
                    begin
                        calc_lvl   = sustain_reg;
                        calc_move  = 1'b1;
                        calc_stage = mtae_pkg::STG_SUSTAIN;
                    end
                    else if (sustain_reg > ceiling_reg)
                    begin
                        calc_lvl = sustain_reg;
                    end
                    else
                    begin
                        calc_ramp     = 1'b1;
                        calc_base     = ceiling_reg;
                        calc_up       = 1'b0;
                        calc_req.diff = ceiling_reg - sustain_reg;
                        calc_req.span = decay_reg;
                    end
                end
                mtae_pkg::STG_SUSTAIN:
                begin
                    calc_lvl = sustain_reg;
                end
                mtae_pkg::STG_RELEASE:
                begin
                    if (elapsed_reg >= TW'(release_reg))
                    begin
                        calc_move  = 1'b1;
                        calc_stage = mtae_pkg::STG_IDLE;
                    end
                    else if (floor_reg <= sustain_reg)
                    begin
                        calc_ramp     = 1'b1;
                        calc_base     = sustain_reg;
                        calc_up       = 1'b0;
                        calc_req.diff = sustain_reg - floor_reg;
                        calc_req.span = release_reg;
                    end
                end
                default:
                begin
                    calc_lvl = floor_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtae_pkg::FSM_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == mtae_pkg::CMD_TICK)
                    begin
                        state_next = mtae_pkg::FSM_WALK;
                    end
                    else if (s_tuser == mtae_pkg::CMD_RESET && trk_ok)
                    begin
                        state_next = mtae_pkg::FSM_FLUSH;
                    end
                end
            end
            mtae_pkg::FSM_WALK:
            begin
                if (trk_active)
                begin
                    state_next = mtae_pkg::FSM_CALC;
                end
                else if (walk_last)
                begin
                    state_next = mtae_pkg::FSM_FLUSH;
                end
            end
            mtae_pkg::FSM_CALC:
            begin
                state_next = calc_ramp ? mtae_pkg::FSM_DIV : mtae_pkg::FSM_EMIT;
            end
            mtae_pkg::FSM_DIV:
            begin
                if (!ramp_busy)
                begin
                    state_next = mtae_pkg::FSM_EMIT;
                end
            end
            mtae_pkg::FSM_EMIT:
            begin
                if (!emit_wait)
                begin
                    state_next = walk_last ? mtae_pkg::FSM_FLUSH : mtae_pkg::FSM_WALK;
                end
            end
            mtae_pkg::FSM_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = mtae_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = mtae_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        enable_next     = enable_reg;
        attack_next     = attack_reg;
        decay_next      = decay_reg;
        sustain_next    = sustain_reg;
        release_next    = release_reg;
        floor_next      = floor_reg;
        ceiling_next    = ceiling_reg;
        stage_next      = stage_reg;
        start_next      = start_reg;
        sent_next       = sent_reg;
        t_next          = t_reg;
        now_next        = now_reg;
        elapsed_next    = elapsed_reg;
        early_next      = early_reg;
        lvl_next        = lvl_reg;
        base_next       = base_reg;
        up_next         = up_reg;
        pend_valid_next = pend_valid_reg;
        pend_track_next = pend_track_reg;
        pend_level_next = pend_level_reg;
        pend_stage_next = pend_stage_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tlast_next    = m_tlast_reg;
        out_track_next  = out_track_reg;
        out_level_next  = out_level_reg;
        out_stage_next  = out_stage_reg;
        ramp_start      = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                mtae_pkg::REG_ENABLE:  enable_next  = cfg_data[mtae_pkg::MASK_W-1:0];
                mtae_pkg::REG_ATTACK:  attack_next  = cfg_data;
                mtae_pkg::REG_DECAY:   decay_next   = cfg_data;
                mtae_pkg::REG_SUSTAIN: sustain_next = cfg_data[LW-1:0];
                mtae_pkg::REG_RELEASE: release_next = cfg_data;
                mtae_pkg::REG_FLOOR:   floor_next   = cfg_data[LW-1:0];
                mtae_pkg::REG_CEILING: ceiling_next = cfg_data[LW-1:0];
                default:               enable_next  = enable_reg;
            endcase
        end

        case (state_reg)
            mtae_pkg::FSM_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == mtae_pkg::CMD_TICK)
                    begin
                        now_next = in_time;
                        t_next   = '0;
                    end
                    else if (trk_ok)
                    begin
                        case (s_tuser)
                            mtae_pkg::CMD_TRIGGER:
                            begin
                                if (en_vec[idx])
                                begin
                                    stage_next[idx] = mtae_pkg::STG_ATTACK;
                                    start_next[idx] = '0;
                                end
                            end
                            mtae_pkg::CMD_RELEASE:
                            begin
                                if (en_vec[idx] && cur_stage != mtae_pkg::STG_IDLE
                                    && cur_stage != mtae_pkg::STG_RELEASE)
                                begin
                                    stage_next[idx] = mtae_pkg::STG_RELEASE;
                                    start_next[idx] = '0;
                                end
                            end
                            default:
                            begin
                                stage_next[idx] = mtae_pkg::STG_IDLE;
                                start_next[idx] = '0;
                                sent_next[idx]  = floor_reg;
                                pend_valid_next = 1'b1;
                                pend_track_next = in_track;
                                pend_level_next = floor_reg;
                                pend_stage_next = mtae_pkg::STG_IDLE;
                            end
                        endcase
                    end
                end
            end
            mtae_pkg::FSM_WALK:
            begin
                if (trk_active)
                begin
                    if (cur_start == '0)
                    begin
                        start_next[idx] = now_reg;
                    end
                    elapsed_next = now_reg - start_eff;
                    early_next   = now_reg < start_eff;
                end
                else if (!walk_last)
                begin
                    t_next = t_reg + IW'(1);
                end
            end
            mtae_pkg::FSM_CALC:
            begin
                lvl_next  = calc_lvl;
                base_next = calc_base;
                up_next   = calc_up;
                if (calc_move)
                begin
                    stage_next[idx] = calc_stage;
                    start_next[idx] = now_reg;
                end
                ramp_start = calc_ramp;
            end
            mtae_pkg::FSM_DIV:
            begin
                if (!ramp_busy)
                begin
                    lvl_next = up_reg ? base_reg + ramp_quot : base_reg - ramp_quot;
                end
            end
            mtae_pkg::FSM_EMIT:
            begin
                if (!emit_wait)
                begin
                    if (emit_change)
                    begin
                        if (pend_valid_reg)
                        begin
                            m_tvalid_next  = 1'b1;
                            m_tlast_next   = 1'b0;
                            out_track_next = pend_track_reg;
                            out_level_next = pend_level_reg;
                            out_stage_next = pend_stage_reg;
                        end
                        sent_next[idx]  = lvl_reg;
                        pend_valid_next = 1'b1;
                        pend_track_next = KW'(t_reg);
                        pend_level_next = lvl_reg;
                        pend_stage_next = cur_stage;
                    end
                    if (!walk_last)
                    begin
                        t_next = t_reg + IW'(1);
                    end
                end
            end
            mtae_pkg::FSM_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    m_tlast_next    = 1'b1;
                    out_track_next  = pend_track_reg;
                    out_level_next  = pend_level_reg;
                    out_stage_next  = pend_stage_reg;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                t_next = t_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mtae_pkg::FSM_IDLE;
            enable_reg     <= mtae_pkg::ENABLE_RST;
            attack_reg     <= mtae_pkg::ATTACK_RST;
            decay_reg      <= mtae_pkg::DECAY_RST;
            sustain_reg    <= mtae_pkg::SUSTAIN_RST;
            release_reg    <= mtae_pkg::RELEASE_RST;
            floor_reg      <= mtae_pkg::FLOOR_RST;
            ceiling_reg    <= mtae_pkg::CEILING_RST;
            for (int i = 0; i < NT; i++)
            begin
                stage_reg[i] <= mtae_pkg::STG_IDLE;
                start_reg[i] <= '0;
                sent_reg[i]  <= '0;
            end
            t_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            enable_reg     <= enable_next;
            attack_reg     <= attack_next;
            decay_reg      <= decay_next;
            sustain_reg    <= sustain_next;
            release_reg    <= release_next;
            floor_reg      <= floor_next;
            ceiling_reg    <= ceiling_next;
            stage_reg      <= stage_next;
            start_reg      <= start_next;
            sent_reg       <= sent_next;
            t_reg          <= t_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        elapsed_reg    <= elapsed_next;
        early_reg      <= early_next;
        lvl_reg        <= lvl_next;
        base_reg       <= base_next;
        up_reg         <= up_next;
        pend_track_reg <= pend_track_next;
        pend_level_reg <= pend_level_next;
        pend_stage_reg <= pend_stage_next;
        m_tlast_reg    <= m_tlast_next;
        out_track_reg  <= out_track_next;
        out_level_reg  <= out_level_next;
        out_stage_reg  <= out_stage_next;
    end

    assign s_tready  = state_reg == mtae_pkg::FSM_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tdata   = {3'b000, out_stage_reg, out_level_reg, out_track_reg};

    // A held result never survives the return to idle.
    a_no_pend_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mtae_pkg::FSM_IDLE |-> !pend_valid_reg)
        else $error("pending result left behind in idle");

    // The divider only runs while the walk waits for it.
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_busy |-> state_reg == mtae_pkg::FSM_DIV)
        else $error("divider busy outside of the division state");

    // A divider start always leads into the division state.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_start |=> ramp_busy && state_reg == mtae_pkg::FSM_DIV)
        else $error("divider start not followed by division");

endmodule

>>> sim/multi_track_adsr_envelope_tb.sv
`timescale 1ns / 1ps

module multi_track_adsr_envelope_tb;

    typedef struct packed {
        logic [mtae_pkg::CMD_W-1:0]  op;
        logic [mtae_pkg::TRK_W-1:0]  trk;
        logic [mtae_pkg::TIME_W-1:0] stamp;
    } env_cmd_t;

    typedef struct packed {
        logic [mtae_pkg::TRK_W-1:0]   trk;
        logic [mtae_pkg::LEVEL_W-1:0] lvl;
        logic [mtae_pkg::STAGE_W-1:0] stg;
        logic                         last;
    } env_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    env_cmd_t    cmd_q[$];
    env_result_t expected_levels[$];
    env_cmd_t    cur_cmd;
    int          pushed_cnt = 0;
    int          accepted_cnt = 0;
    int          err_cnt = 0;
    int          in_wait = 0;
    int          out_wait = 0;
    bit          in_fast = 1'b0;
    bit          out_fast = 1'b0;

    // Shadow copy of the shared settings and the per-track envelope state.
    logic [mtae_pkg::MASK_W-1:0]  mask_r = mtae_pkg::ENABLE_RST;
    logic [mtae_pkg::SPAN_W-1:0]  atk_r = mtae_pkg::ATTACK_RST;
    logic [mtae_pkg::SPAN_W-1:0]  dec_r = mtae_pkg::DECAY_RST;
    logic [mtae_pkg::LEVEL_W-1:0] sus_r = mtae_pkg::SUSTAIN_RST;
    logic [mtae_pkg::SPAN_W-1:0]  rel_r = mtae_pkg::RELEASE_RST;
    logic [mtae_pkg::LEVEL_W-1:0] flo_r = mtae_pkg::FLOOR_RST;
    logic [mtae_pkg::LEVEL_W-1:0] cei_r = mtae_pkg::CEILING_RST;
    logic [mtae_pkg::STAGE_W-1:0] stage_q[8] = '{default: mtae_pkg::STG_IDLE};
    logic [mtae_pkg::TIME_W-1:0]  start_q[8] = '{default: '0};
    logic [mtae_pkg::LEVEL_W-1:0] sent_q[8] = '{default: '0};

    multi_track_adsr_envelope #(.TRACKS(8)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        if (err_cnt < 40)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    function automatic int draw_gap(input bit fast);
        return fast ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [mtae_pkg::LEVEL_W-1:0] ramp_between(
            input logic [mtae_pkg::LEVEL_W-1:0] a,
            input logic [mtae_pkg::LEVEL_W-1:0] b,
            input logic [mtae_pkg::TIME_W-1:0] el,
            input logic [mtae_pkg::SPAN_W-1:0] span);
        logic [63:0] d;
        if (b >= a)
        begin
            d = ((64'(b) - 64'(a)) * 64'(el)) / 64'(span);
            return a + d[mtae_pkg::LEVEL_W-1:0];
        end
        d = ((64'(a) - 64'(b)) * 64'(el)) / 64'(span);
        return a - d[mtae_pkg::LEVEL_W-1:0];
    endfunction

    function automatic logic [mtae_pkg::LEVEL_W-1:0] envelope_level(
            input int t,
            input logic [mtae_pkg::TIME_W-1:0] now);
        logic [mtae_pkg::TIME_W-1:0]  el;
        logic [mtae_pkg::LEVEL_W-1:0] v;
        if (now < start_q[t])
            return flo_r;
        el = now - start_q[t];
        case (stage_q[t])
            mtae_pkg::STG_ATTACK:
            begin
                if (el >= 32'(atk_r))
                begin
                    v = cei_r;
                    stage_q[t] = mtae_pkg::STG_DECAY;
                    start_q[t] = now;
                end
                else if (flo_r > cei_r)
                    v = flo_r;
                else
                    v = ramp_between(flo_r, cei_r, el, atk_r);
            end
            mtae_pkg::STG_DECAY:
            begin
                if (el >= 32'(dec_r))
                begin
                    v = sus_r;
                    stage_q[t] = mtae_pkg::STG_SUSTAIN;
                    start_q[t] = now;
                end
                else if (sus_r > cei_r)
                    v = sus_r;
                else
                    v = ramp_between(cei_r, sus_r, el, dec_r);
            end
            mtae_pkg::STG_SUSTAIN:
                v = sus_r;
            mtae_pkg::STG_RELEASE:
            begin
                if (el >= 32'(rel_r))
                begin
                    v = flo_r;
                    stage_q[t] = mtae_pkg::STG_IDLE;
                    start_q[t] = now;
                end
                else if (flo_r > sus_r)
                    v = flo_r;
                else
                    v = ramp_between(sus_r, flo_r, el, rel_r);
            end
            default:
                v = flo_r;
        endcase
        return v;
    endfunction

    task automatic predict_envelope(input env_cmd_t c);
        env_result_t                  batch[$];
        logic [mtae_pkg::LEVEL_W-1:0] lvl;
        int                           trk;
        trk = c.trk;
        case (c.op)
            mtae_pkg::CMD_TICK:
            begin
                for (int t = 0; t < 8; t++)
                begin
                    if (!mask_r[t])
                        continue;
                    if (start_q[t] == '0 && stage_q[t] != mtae_pkg::STG_IDLE)
                        start_q[t] = c.stamp;
                    if (stage_q[t] == mtae_pkg::STG_IDLE)
                        continue;
                    lvl = envelope_level(t, c.stamp);
                    if (lvl != sent_q[t])
                    begin
                        sent_q[t] = lvl;
                        batch.push_back('{trk: 3'(t), lvl: lvl, stg: stage_q[t], last: 1'b0});
                    end
                end
                if (batch.size() != 0)
                    batch[batch.size()-1].last = 1'b1;
                foreach (batch[i])
                    expected_levels.push_back(batch[i]);
            end
            mtae_pkg::CMD_TRIGGER:
            begin
                if (mask_r[trk])
                begin
                    stage_q[trk] = mtae_pkg::STG_ATTACK;
                    start_q[trk] = '0;
                end
            end
            mtae_pkg::CMD_RELEASE:
            begin
                if (mask_r[trk] && stage_q[trk] != mtae_pkg::STG_IDLE
                    && stage_q[trk] != mtae_pkg::STG_RELEASE)
                begin
                    stage_q[trk] = mtae_pkg::STG_RELEASE;
                    start_q[trk] = '0;
                end
            end
            default:
            begin
                stage_q[trk] = mtae_pkg::STG_IDLE;
                sent_q[trk] = flo_r;
                start_q[trk] = '0;
                expected_levels.push_back('{trk: c.trk, lvl: flo_r,
                                            stg: mtae_pkg::STG_IDLE, last: 1'b1});
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            in_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_envelope(cur_cmd);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_wait != 0)
                begin
                    in_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_q.size() != 0)
                begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'd0, cur_cmd.stamp, cur_cmd.trk};
                    s_tuser <= cur_cmd.op;
                    if ($urandom_range(0, 15) == 0)
                        in_fast = !in_fast;
                    in_wait = draw_gap(in_fast);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        env_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_levels.size() == 0)
                    flag_mismatch($sformatf("unexpected transfer track %0d level %0d stage %0d",
                                            m_tdata[2:0], m_tdata[9:3], m_tdata[12:10]));
                else
                begin
                    want = expected_levels.pop_front();
                    if (m_tdata[2:0] !== want.trk || m_tdata[9:3] !== want.lvl ||
                        m_tdata[12:10] !== want.stg || m_tlast !== want.last)
                        flag_mismatch($sformatf(
                            "got trk %0d lvl %0d stg %0d last %0d, want %0d %0d %0d %0d",
                            m_tdata[2:0], m_tdata[9:3], m_tdata[12:10], m_tlast,
                            want.trk, want.lvl, want.stg, want.last));
                end
                if ($urandom_range(0, 15) == 0)
                    out_fast = !out_fast;
                out_wait = draw_gap(out_fast);
            end
            else if (out_wait != 0 && !m_tready)
                out_wait--;
            m_tready <= (out_wait == 0);
        end
    end

    task automatic write_reg(input logic [mtae_pkg::REG_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            mtae_pkg::REG_ENABLE:  mask_r = val[mtae_pkg::MASK_W-1:0];
            mtae_pkg::REG_ATTACK:  atk_r = val;
            mtae_pkg::REG_DECAY:   dec_r = val;
            mtae_pkg::REG_SUSTAIN: sus_r = val[mtae_pkg::LEVEL_W-1:0];
            mtae_pkg::REG_RELEASE: rel_r = val;
            mtae_pkg::REG_FLOOR:   flo_r = val[mtae_pkg::LEVEL_W-1:0];
            mtae_pkg::REG_CEILING: cei_r = val[mtae_pkg::LEVEL_W-1:0];
            default:               ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] en, input logic [15:0] atk,
                             input logic [15:0] dec, input logic [6:0] sus,
                             input logic [15:0] rel, input logic [6:0] flo,
                             input logic [6:0] cei);
        write_reg(mtae_pkg::REG_ENABLE, 16'(en));
        write_reg(mtae_pkg::REG_ATTACK, atk);
        write_reg(mtae_pkg::REG_DECAY, dec);
        write_reg(mtae_pkg::REG_SUSTAIN, 16'(sus));
        write_reg(mtae_pkg::REG_RELEASE, rel);
        write_reg(mtae_pkg::REG_FLOOR, 16'(flo));
        write_reg(mtae_pkg::REG_CEILING, 16'(cei));
    endtask

    task automatic push_item(input logic [1:0] op, input logic [2:0] trk,
                             input logic [31:0] stamp);
        cmd_q.push_back('{op: op, trk: trk, stamp: stamp});
        pushed_cnt++;
    endtask

    // A tick that produces no transfer may still be walking the tracks, so the
    // block is given extra cycles before it counts as idle.
    task automatic settle();
        while (accepted_cnt != pushed_cnt || expected_levels.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_span();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [6:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    initial
    begin
        logic [31:0] now;
        logic [2:0]  trk;
        int          sel;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        write_all(8'h85, 16'd10, 16'd0, 7'd50, 16'd20, 7'd0, 7'd127);
        push_item(mtae_pkg::CMD_TRIGGER, 3'd0, 32'd0);
        push_item(mtae_pkg::CMD_TRIGGER, 3'd7, 32'hFFFF_FFFF);
        push_item(mtae_pkg::CMD_TRIGGER, 3'd1, 32'd0);
        push_item(mtae_pkg::CMD_RELEASE, 3'd2, 32'd0);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd0);
        push_item(mtae_pkg::CMD_TICK, 3'd7, 32'd5);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd10);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd15);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd16);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd17);
        push_item(mtae_pkg::CMD_RELEASE, 3'd0, 32'd0);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd20);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd30);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd3);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd40);
        push_item(mtae_pkg::CMD_RESET, 3'd1, 32'd0);
        push_item(mtae_pkg::CMD_RESET, 3'd7, 32'd0);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'hFFFF_FFFF);
        settle();

        write_all(8'hFF, 16'hFFFF, 16'hFFFF, 7'd100, 16'hFFFF, 7'd127, 7'd0);
        push_item(mtae_pkg::CMD_TRIGGER, 3'd3, 32'd0);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd1000);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd70000);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd71000);
        push_item(mtae_pkg::CMD_RELEASE, 3'd3, 32'd0);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'd72000);
        push_item(mtae_pkg::CMD_TICK, 3'd0, 32'hFFFF_FFFF);
        push_item(mtae_pkg::CMD_RESET, 3'd3, 32'd0);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_all((ph == 0) ? 8'hFF : 8'($urandom_range(0, 255) | $urandom_range(0, 255)),
                      rand_span(), rand_span(), rand_level(), rand_span(),
                      rand_level(), rand_level());
            now = (ph % 2 == 1) ? $urandom() : 32'($urandom_range(1, 1000));
            for (int k = 0; k < 26; k++)
            begin
                sel = $urandom_range(0, 99);
                trk = 3'($urandom_range(0, 7));
                if (sel < 55)
                begin
                    now = now + 32'($urandom_range(0, 24));
                    push_item(mtae_pkg::CMD_TICK, trk, now);
                end
                else if (sel < 72)
                    push_item(mtae_pkg::CMD_TRIGGER, trk, $urandom());
                else if (sel < 85)
                    push_item(mtae_pkg::CMD_RELEASE, trk, $urandom());
                else if (sel < 92)
                    push_item(mtae_pkg::CMD_RESET, trk, $urandom());
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       push_item(mtae_pkg::CMD_TICK, trk, 32'd0);
                        1:       push_item(mtae_pkg::CMD_TICK, trk, $urandom());
                        default: push_item(mtae_pkg::CMD_TICK, trk,
                                           now - 32'($urandom_range(1, 50)));
                    endcase
                end
            end
            settle();
        end

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
